// File: rtl/core/mmpef_pkg.sv
`default_nettype none
package mmpef_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam logic [7:0]  STATUS_MIN      = 8'h80;
  localparam int unsigned EVT_W           = 24;
  localparam int unsigned FILL_OUT_W      = 4;

  typedef enum logic [1:0] {
    CMD_LINK = 2'd0,
    CMD_PUSH = 2'd1,
    CMD_POP  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    Q_IDLE     = 1'b0,
    Q_POP_WAIT = 1'b1
  } q_state_t;

  // Event offered to the queue by the parser stage.
  typedef struct packed {
    logic       push;
    logic [7:0] status;
    logic [7:0] first_data;
    logic [7:0] second_data;
  } evt_req_t;

endpackage
`default_nettype wire

// File: rtl/core/mmpef_ram.sv
`default_nettype none
module mmpef_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/core/mmpef_parser.sv
`default_nettype none
module mmpef_parser
  import mmpef_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire cmd_t       cmd,
  input  wire logic [7:0] link_byte,
  input  wire logic [7:0] push_status,
  input  wire logic [7:0] push_first_data,
  input  wire logic [7:0] push_second_data,
  output evt_req_t        req
);

  logic       awaiting_r,  awaiting_nxt;
  logic [7:0] status_r,    status_nxt;
  logic [7:0] first_r,     first_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b0;
      status_r   <= 8'h00;
      first_r    <= 8'h00;
    end else begin
      awaiting_r <= awaiting_nxt;
      status_r   <= status_nxt;
      first_r    <= first_nxt;
    end
  end

  always_comb begin
    awaiting_nxt    = awaiting_r;
    status_nxt      = status_r;
    first_nxt       = first_r;
    req.push        = 1'b0;
    req.status      = status_r;
    req.first_data  = first_r;
    req.second_data = link_byte;
    unique case (cmd)
      CMD_LINK: begin
        // Any status byte, real-time ones included, restarts collection.
        if (link_byte >= STATUS_MIN) begin
          if (accept) begin
            status_nxt   = link_byte;
            awaiting_nxt = 1'b0;
          end
        end else if (!awaiting_r) begin
          if (accept) begin
            first_nxt    = link_byte;
            awaiting_nxt = 1'b1;
          end
        end else begin
          req.push = 1'b1;
          if (accept) begin
            awaiting_nxt = 1'b0;
          end
        end
      end
      CMD_PUSH: begin
        req.push        = 1'b1;
        req.status      = push_status;
        req.first_data  = push_first_data;
        req.second_data = push_second_data;
      end
      CMD_POP, CMD_NOP: begin
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/mmpef_queue.sv
`default_nettype none
module mmpef_queue
  import mmpef_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire cmd_t                  cmd,
  input  wire evt_req_t              req,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       ev_valid,
  output logic [7:0]                 ev_status,
  output logic [7:0]                 ev_first_data,
  output logic [7:0]                 ev_second_data,
  output logic                       ev_dropped,
  output logic [FILL_OUT_W-1:0]      ev_fill
);

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = (PTR_W + 1 > FILL_OUT_W) ? PTR_W + 1 : FILL_OUT_W;
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);

  q_state_t                state_r, state_nxt;
  logic [PTR_W-1:0]        wp_r, wp_nxt;
  logic [PTR_W-1:0]        rp_r, rp_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    ev_valid_r, ev_valid_nxt;
  logic [7:0]              ev_status_r, ev_status_nxt;
  logic [7:0]              ev_first_r, ev_first_nxt;
  logic [7:0]              ev_second_r, ev_second_nxt;
  logic                    ev_dropped_r, ev_dropped_nxt;
  logic [FILL_OUT_W-1:0]   ev_fill_r, ev_fill_nxt;

  logic                    accept;
  logic [PTR_W-1:0]        wp_inc, rp_inc;
  logic                    full, empty, do_pop, do_write;
  logic [FILL_W-1:0]       fill;
  logic [EVT_W-1:0]        ram_rdata;

  assign accept = in_valid && in_ready;
  assign wp_inc = (wp_r == LAST_IDX) ? '0 : wp_r + PTR_W'(1);
  assign rp_inc = (rp_r == LAST_IDX) ? '0 : rp_r + PTR_W'(1);
  assign full   = (wp_inc == rp_r);
  assign empty  = (wp_r == rp_r);
  assign do_pop   = accept && (cmd == CMD_POP) && !empty;
  assign do_write = accept && req.push && !full;

  // Occupancy after this item, from the updated pointers.
  always_comb begin
    if (wp_nxt >= rp_nxt) begin
      fill = FILL_W'(wp_nxt) - FILL_W'(rp_nxt);
    end else begin
      fill = FILL_W'(QUEUE_DEPTH) - FILL_W'(rp_nxt) + FILL_W'(wp_nxt);
    end
  end

  mmpef_ram #(
    .WIDTH (EVT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (do_write),
    .waddr (wp_r),
    .wdata ({req.status, req.first_data, req.second_data}),
    .re    (do_pop),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= Q_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_valid_r   <= ev_valid_nxt;
    ev_status_r  <= ev_status_nxt;
    ev_first_r   <= ev_first_nxt;
    ev_second_r  <= ev_second_nxt;
    ev_dropped_r <= ev_dropped_nxt;
    ev_fill_r    <= ev_fill_nxt;
  end

  // A new item is taken only when the result register is free by the next edge.
  assign in_ready = (state_r == Q_IDLE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = do_write ? wp_inc : wp_r;
    rp_nxt         = do_pop ? rp_inc : rp_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    ev_valid_nxt   = ev_valid_r;
    ev_status_nxt  = ev_status_r;
    ev_first_nxt   = ev_first_r;
    ev_second_nxt  = ev_second_r;
    ev_dropped_nxt = ev_dropped_r;
    ev_fill_nxt    = ev_fill_r;
    unique case (state_r)
      Q_IDLE: begin
        if (accept) begin
          ev_valid_nxt   = 1'b0;
          ev_status_nxt  = 8'h00;
          ev_first_nxt   = 8'h00;
          ev_second_nxt  = 8'h00;
          ev_dropped_nxt = req.push && full;
          ev_fill_nxt    = fill[FILL_OUT_W-1:0];
          if (do_pop) begin
            state_nxt     = Q_POP_WAIT;
            out_valid_nxt = 1'b0;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      Q_POP_WAIT: begin
        ev_valid_nxt  = 1'b1;
        ev_status_nxt = ram_rdata[23:16];
        ev_first_nxt  = ram_rdata[15:8];
        ev_second_nxt = ram_rdata[7:0];
        out_valid_nxt = 1'b1;
        state_nxt     = Q_IDLE;
      end
      default: begin
        state_nxt = Q_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign ev_valid       = ev_valid_r;
  assign ev_status      = ev_status_r;
  assign ev_first_data  = ev_first_r;
  assign ev_second_data = ev_second_r;
  assign ev_dropped     = ev_dropped_r;
  assign ev_fill        = ev_fill_r;

  a_wait_result_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == Q_POP_WAIT) |-> !out_valid_r)
    else $error("result register busy while a pop read is outstanding");

  a_drop_keeps_wp: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && req.push && full) |=> $stable(wp_r))
    else $error("write pointer moved on a dropped push");

  a_pop_gives_event: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> (state_r == Q_POP_WAIT) ##1 (out_valid_r && ev_valid_r))
    else $error("pop of a non-empty queue did not return an event");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r <= LAST_IDX) && (rp_r <= LAST_IDX))
    else $error("queue pointer beyond the last entry");

  a_valid_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(ev_valid_r && ev_dropped_r))
    else $error("result reports both an event and a drop");

endmodule
`default_nettype wire

// File: rtl/core/midi_message_parser_event_fifo.sv
// Channel   Dir  Handshake             Payload
// in_       in   in_tvalid/in_tready   tuser: cmd; tdata: link byte, pushed event
// out_      out  out_tvalid/out_tready tuser: event_valid, dropped; tdata: event, fill
//
// Every item gives exactly one result. A pop of a non-empty queue passes through
// a wait state for the registered read of the event store; all other items go
// straight to the result register and are taken once per cycle unless it stalls.
// Synchronous active-low reset empties the queue and clears the parser; the
// event store itself is not cleared. A stalled result holds off further items.
`default_nettype none
module midi_message_parser_event_fifo
  import mmpef_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] link_byte, [15:8] push_status, [23:16] push_first_data,
  // [31:24] push_second_data
  input  wire logic [31:0] in_tdata,
  // [1:0] cmd
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] event_status, [15:8] event_first_data, [23:16] event_second_data,
  // [27:24] fill_level, [31:28] zero
  output logic [31:0]      out_tdata,
  // [0] event_valid, [1] dropped
  output logic [1:0]       out_tuser
);

  cmd_t                  cmd;
  evt_req_t              req;
  logic                  in_accept;
  logic                  ev_valid, ev_dropped;
  logic [7:0]            ev_status, ev_first, ev_second;
  logic [FILL_OUT_W-1:0] ev_fill;

  assign cmd       = cmd_t'(in_tuser);
  assign in_accept = in_tvalid && in_tready;

  mmpef_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (in_accept),
    .cmd              (cmd),
    .link_byte        (in_tdata[7:0]),
    .push_status      (in_tdata[15:8]),
    .push_first_data  (in_tdata[23:16]),
    .push_second_data (in_tdata[31:24]),
    .req              (req)
  );

  mmpef_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .cmd            (cmd),
    .req            (req),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .ev_valid       (ev_valid),
    .ev_status      (ev_status),
    .ev_first_data  (ev_first),
    .ev_second_data (ev_second),
    .ev_dropped     (ev_dropped),
    .ev_fill        (ev_fill)
  );

  assign out_tdata = {4'h0, ev_fill, ev_second, ev_first, ev_status};
  assign out_tuser = {ev_dropped, ev_valid};

endmodule
`default_nettype wire
